@@ rtl/pbrf_pkg.sv @@
// Shared types, codes and constants of the polled bus bridge register file.
package pbrf_pkg;

  localparam int FILE_WORDS_DEF   = 20;
  localparam int POLLED_COUNT_DEF = 3;
  localparam int FILE_REG_OFFSET  = 2;

  localparam logic [7:0]  BOOT_PING_RST = 8'd1;
  localparam logic [7:0]  PING_RST      = 8'd2;
  localparam logic [7:0]  ACK_RST       = 8'd85;
  localparam logic [7:0]  POLL0_RST     = 8'd0;
  localparam logic [7:0]  POLL1_RST     = 8'd1;
  localparam logic [7:0]  POLL2_RST     = 8'd2;
  localparam logic [15:0] READ_BASE_RST = 16'd1000;

  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_REQUEST = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [1:0] KIND_REPLY  = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] CFG_BOOT_PING = 3'd0;
  localparam logic [2:0] CFG_PING      = 3'd1;
  localparam logic [2:0] CFG_ACK       = 3'd2;
  localparam logic [2:0] CFG_POLL0     = 3'd3;
  localparam logic [2:0] CFG_POLL1     = 3'd4;
  localparam logic [2:0] CFG_POLL2     = 3'd5;
  localparam logic [2:0] CFG_READ_BASE = 3'd6;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ECHO,
    PH_LO,
    PH_HI
  } phase_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_INC,
    CTL_STREAM
  } ctl_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic [15:0] read_address;
    logic [15:0] read_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  reply_byte;
    logic [15:0] reg_word;
    logic        read_status;
    logic        last;
  } out_item_t;

endpackage

@@ rtl/pbrf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pbrf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/poll_bridge_register_file_unit.sv @@
// Top level of the polled bus bridge with its readable word file.
// A received byte is handled in the idle state; incrementing a ping counter adds the counter-increment state.
// A request or a failed or empty read puts its item in the output queue in the cycle after acceptance.
// A block read goes through the stream state and the read register of the file memory, then
// delivers one word per cycle while the two-entry output queue has room (single read port).
// Synchronous reset clears the control state and the file's valid bits; the file reads as zero.
module poll_bridge_register_file_unit #(
  parameter int FILE_WORDS   = pbrf_pkg::FILE_WORDS_DEF,
  parameter int POLLED_COUNT = pbrf_pkg::POLLED_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pbrf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pbrf_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int AW = $clog2(FILE_WORDS);
  localparam int CW = $clog2(FILE_WORDS + 1);

  logic [7:0]  boot_ping_r, ping_r, ack_r, poll0_r, poll1_r, poll2_r;
  logic [15:0] read_base_r;

  pbrf_pkg::phase_t phase_r, phase_nxt;
  pbrf_pkg::ctl_t   ctl_r, ctl_nxt;
  logic [1:0]  poll_idx_r, poll_idx_nxt;
  logic [7:0]  cur_reg_r, cur_reg_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [7:0]  reply_r, reply_nxt;
  logic        inc_addr_r, inc_addr_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic        infl_r, infl_nxt;
  logic        infl_last_r, infl_last_nxt;

  logic [FILE_WORDS-1:0] vld_r, vld_nxt;
  logic        rd_vld_r;

  pbrf_pkg::out_item_t q_r [2];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wp_r, rp_r;

  logic        in_acc, pop, push, issue;
  pbrf_pkg::out_item_t push_d;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0] mem_wdata, mem_q, file_word;
  logic [16:0] rd_end, rd_lim;
  logic        range_bad;
  logic [8:0]  store_idx;
  logic [7:0]  poll_sel;
  logic [1:0]  occ, occ_after;

  pbrf_ram #(
    .WIDTH(16),
    .DEPTH(FILE_WORDS)
  ) u_file (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_addr(mem_raddr),
    .rd_data(mem_q)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_ping_r <= pbrf_pkg::BOOT_PING_RST;
      ping_r      <= pbrf_pkg::PING_RST;
      ack_r       <= pbrf_pkg::ACK_RST;
      poll0_r     <= pbrf_pkg::POLL0_RST;
      poll1_r     <= pbrf_pkg::POLL1_RST;
      poll2_r     <= pbrf_pkg::POLL2_RST;
      read_base_r <= pbrf_pkg::READ_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pbrf_pkg::CFG_BOOT_PING: boot_ping_r <= cfg_data[7:0];
        pbrf_pkg::CFG_PING:      ping_r      <= cfg_data[7:0];
        pbrf_pkg::CFG_ACK:       ack_r       <= cfg_data[7:0];
        pbrf_pkg::CFG_POLL0:     poll0_r     <= cfg_data[7:0];
        pbrf_pkg::CFG_POLL1:     poll1_r     <= cfg_data[7:0];
        pbrf_pkg::CFG_POLL2:     poll2_r     <= cfg_data[7:0];
        pbrf_pkg::CFG_READ_BASE: read_base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[rp_r];
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (ctl_r != pbrf_pkg::CTL_IDLE) || (cnt_r == 2'd2);
  assign in_acc    = in_valid && !in_stall;

  assign file_word = rd_vld_r ? mem_q : 16'd0;
  assign rd_end    = {1'b0, in_data.read_address} + {1'b0, in_data.read_count};
  assign rd_lim    = {1'b0, read_base_r} + 17'(FILE_WORDS);
  assign range_bad = (in_data.read_address < read_base_r) || (rd_end > rd_lim);
  assign store_idx = 9'(pbrf_pkg::FILE_REG_OFFSET) + {1'b0, cur_reg_r};
  assign occ       = cnt_r + {1'b0, infl_r};
  assign occ_after = occ - {1'b0, pop};

  always_comb begin
    case (poll_idx_r)
      2'd0:    poll_sel = poll0_r;
      2'd1:    poll_sel = poll1_r;
      default: poll_sel = poll2_r;
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    ctl_nxt       = ctl_r;
    poll_idx_nxt  = poll_idx_r;
    cur_reg_nxt   = cur_reg_r;
    low_nxt       = low_r;
    reply_nxt     = reply_r;
    inc_addr_nxt  = inc_addr_r;
    rd_addr_nxt   = rd_addr_r;
    left_nxt      = left_r;
    infl_nxt      = 1'b0;
    infl_last_nxt = infl_last_r;
    vld_nxt       = vld_r;
    mem_we        = 1'b0;
    mem_waddr     = store_idx[AW-1:0];
    mem_wdata     = {in_data.data_byte, low_r};
    mem_raddr     = rd_addr_r;
    push          = 1'b0;
    push_d        = '0;
    issue         = 1'b0;

    case (ctl_r)
      pbrf_pkg::CTL_IDLE: begin
        if (in_acc) begin
          case (in_data.command)
            pbrf_pkg::CMD_BYTE: begin
              case (phase_r)
                pbrf_pkg::PH_IDLE: begin
                  if (in_data.data_byte == boot_ping_r) begin
                    reply_nxt    = ack_r;
                    inc_addr_nxt = 1'b0;
                    mem_raddr    = '0;
                    ctl_nxt      = pbrf_pkg::CTL_INC;
                  end else if (in_data.data_byte == ping_r) begin
                    if (32'(poll_idx_r) < POLLED_COUNT) begin
                      cur_reg_nxt  = poll_sel;
                      reply_nxt    = poll_sel;
                      poll_idx_nxt = poll_idx_r + 2'd1;
                      phase_nxt    = pbrf_pkg::PH_ECHO;
                    end else begin
                      reply_nxt    = ack_r;
                      inc_addr_nxt = 1'b1;
                      mem_raddr    = AW'(1);
                      ctl_nxt      = pbrf_pkg::CTL_INC;
                    end
                  end else begin
                    cur_reg_nxt = in_data.data_byte;
                    phase_nxt   = pbrf_pkg::PH_LO;
                  end
                end
                pbrf_pkg::PH_ECHO: begin
                  phase_nxt = (in_data.data_byte == cur_reg_r) ? pbrf_pkg::PH_LO
                                                               : pbrf_pkg::PH_IDLE;
                end
                pbrf_pkg::PH_LO: begin
                  low_nxt   = in_data.data_byte;
                  phase_nxt = pbrf_pkg::PH_HI;
                end
                default: begin
                  if (32'(store_idx) < FILE_WORDS) begin
                    mem_we                         = 1'b1;
                    vld_nxt[store_idx[AW-1:0]]     = 1'b1;
                  end
                  phase_nxt = pbrf_pkg::PH_IDLE;
                end
              endcase
            end
            pbrf_pkg::CMD_REQUEST: begin
              push              = 1'b1;
              push_d.kind       = pbrf_pkg::KIND_REPLY;
              push_d.reply_byte = reply_r;
              push_d.last       = 1'b1;
            end
            pbrf_pkg::CMD_READ: begin
              if (range_bad || (in_data.read_count == 16'd0)) begin
                push               = 1'b1;
                push_d.kind        = pbrf_pkg::KIND_STATUS;
                push_d.read_status = range_bad;
                push_d.last        = 1'b1;
              end else begin
                rd_addr_nxt = AW'(in_data.read_address - read_base_r);
                left_nxt    = CW'(in_data.read_count);
                ctl_nxt     = pbrf_pkg::CTL_STREAM;
              end
            end
            default: ;
          endcase
        end
      end
      pbrf_pkg::CTL_INC: begin
        mem_we                 = 1'b1;
        mem_waddr              = AW'(inc_addr_r);
        mem_wdata              = file_word + 16'd1;
        vld_nxt[AW'(inc_addr_r)] = 1'b1;
        ctl_nxt                = pbrf_pkg::CTL_IDLE;
      end
      pbrf_pkg::CTL_STREAM: begin
        if (infl_r) begin
          push            = 1'b1;
          push_d.kind     = pbrf_pkg::KIND_WORD;
          push_d.reg_word = file_word;
          push_d.last     = infl_last_r;
        end
        if ((left_r != '0) && (occ_after < 2'd2)) begin
          issue         = 1'b1;
          mem_raddr     = rd_addr_r;
          rd_addr_nxt   = rd_addr_r + AW'(1);
          left_nxt      = left_r - CW'(1);
          infl_nxt      = 1'b1;
          infl_last_nxt = (left_r == CW'(1));
        end
        if ((left_r == '0) && !infl_r) begin
          ctl_nxt = pbrf_pkg::CTL_IDLE;
        end
      end
      default: ctl_nxt = pbrf_pkg::CTL_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= pbrf_pkg::PH_IDLE;
      ctl_r      <= pbrf_pkg::CTL_IDLE;
      poll_idx_r <= 2'd0;
      cur_reg_r  <= 8'd0;
      low_r      <= 8'd0;
      reply_r    <= 8'd0;
      left_r     <= '0;
      infl_r     <= 1'b0;
      vld_r      <= '0;
      cnt_r      <= 2'd0;
      wp_r       <= 1'b0;
      rp_r       <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      ctl_r      <= ctl_nxt;
      poll_idx_r <= poll_idx_nxt;
      cur_reg_r  <= cur_reg_nxt;
      low_r      <= low_nxt;
      reply_r    <= reply_nxt;
      left_r     <= left_nxt;
      infl_r     <= infl_nxt;
      vld_r      <= vld_nxt;
      cnt_r      <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    inc_addr_r  <= inc_addr_nxt;
    rd_addr_r   <= rd_addr_nxt;
    infl_last_r <= infl_last_nxt;
    rd_vld_r    <= vld_r[mem_raddr];
    if (push) begin
      q_r[wp_r] <= push_d;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("Output queue holds more than two items.");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'd2) || pop)
    else $error("Item pushed into a full output queue.");

  a_inc_follows_ping: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r == pbrf_pkg::CTL_INC |=> ctl_r == pbrf_pkg::CTL_IDLE)
    else $error("Counter update did not finish in one cycle.");

  a_read_in_file: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> 32'(rd_addr_r) < FILE_WORDS)
    else $error("Block read addresses a word beyond the file.");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the polled bus bridge register file unit.
`timescale 1ns / 100ps

module tb;

  localparam int FILE_WORDS = pbrf_pkg::FILE_WORDS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int SQUEEZE_CYCLES = 400;

  typedef struct {
    pbrf_pkg::in_item_t item;
    bit                 drain_first;
  } stim_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  pbrf_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  pbrf_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;

  stim_t               send_queue[$];
  stim_t               next_stim;
  pbrf_pkg::out_item_t awaited_results[$];
  pbrf_pkg::out_item_t want;
  pbrf_pkg::in_item_t  drain_item;

  logic [7:0]  boot_code;
  logic [7:0]  ping_cmd;
  logic [7:0]  ack_val;
  logic [7:0]  poll_regs[3];
  logic [15:0] base_addr;

  pbrf_pkg::phase_t mphase;
  int          polls_done;
  logic [7:0]  cur_reg;
  logic [7:0]  held_low;
  logic [7:0]  reply_reg;
  logic [15:0] words[FILE_WORDS];

  int mismatches = 0;
  int cycles = 0;
  int burst_left = 1;
  int gap_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int squeeze_left = 0;
  bit squeeze_done = 1'b0;
  logic squeeze_req = 1'b0;

  poll_bridge_register_file_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, exp_val));
  endtask

  task automatic push_result(input logic [1:0] kind, input logic [7:0] rb,
                             input logic [15:0] word, input logic status,
                             input logic fin);
    pbrf_pkg::out_item_t r;
    r.kind = kind;
    r.reply_byte = rb;
    r.reg_word = word;
    r.read_status = status;
    r.last = fin;
    awaited_results.push_back(r);
  endtask

  task automatic predict_item(input pbrf_pkg::in_item_t it);
    logic [16:0] span_end;
    logic [16:0] file_end;
    int offs;
    int slot;
    case (it.command)
      pbrf_pkg::CMD_BYTE: begin
        case (mphase)
          pbrf_pkg::PH_IDLE: begin
            if (it.data_byte == boot_code) begin
              reply_reg = ack_val;
              words[0] = words[0] + 16'd1;
            end else if (it.data_byte == ping_cmd) begin
              if (polls_done < pbrf_pkg::POLLED_COUNT_DEF) begin
                cur_reg = poll_regs[polls_done];
                reply_reg = cur_reg;
                polls_done++;
                mphase = pbrf_pkg::PH_ECHO;
              end else begin
                reply_reg = ack_val;
                words[1] = words[1] + 16'd1;
              end
            end else begin
              cur_reg = it.data_byte;
              mphase = pbrf_pkg::PH_LO;
            end
          end
          pbrf_pkg::PH_ECHO: begin
            mphase = (it.data_byte == cur_reg) ? pbrf_pkg::PH_LO : pbrf_pkg::PH_IDLE;
          end
          pbrf_pkg::PH_LO: begin
            held_low = it.data_byte;
            mphase = pbrf_pkg::PH_HI;
          end
          default: begin
            slot = pbrf_pkg::FILE_REG_OFFSET + int'(cur_reg);
            if (slot < FILE_WORDS) words[slot] = {it.data_byte, held_low};
            mphase = pbrf_pkg::PH_IDLE;
          end
        endcase
      end
      pbrf_pkg::CMD_REQUEST: begin
        push_result(pbrf_pkg::KIND_REPLY, reply_reg, 16'd0, 1'b0, 1'b1);
      end
      pbrf_pkg::CMD_READ: begin
        span_end = {1'b0, it.read_address} + {1'b0, it.read_count};
        file_end = {1'b0, base_addr} + 17'(FILE_WORDS);
        if (it.read_address < base_addr || span_end > file_end) begin
          push_result(pbrf_pkg::KIND_STATUS, 8'd0, 16'd0, 1'b1, 1'b1);
        end else if (it.read_count == 16'd0) begin
          push_result(pbrf_pkg::KIND_STATUS, 8'd0, 16'd0, 1'b0, 1'b1);
        end else begin
          offs = int'(it.read_address) - int'(base_addr);
          for (int k = 0; k < int'(it.read_count); k++)
            push_result(pbrf_pkg::KIND_WORD, 8'd0, words[offs + k], 1'b0,
                        (k + 1 == int'(it.read_count)));
        end
      end
      default: ;
    endcase
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pbrf_pkg::CFG_BOOT_PING: boot_code = val[7:0];
      pbrf_pkg::CFG_PING:      ping_cmd = val[7:0];
      pbrf_pkg::CFG_ACK:       ack_val = val[7:0];
      pbrf_pkg::CFG_POLL0:     poll_regs[0] = val[7:0];
      pbrf_pkg::CFG_POLL1:     poll_regs[1] = val[7:0];
      pbrf_pkg::CFG_POLL2:     poll_regs[2] = val[7:0];
      pbrf_pkg::CFG_READ_BASE: base_addr = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_cfg(input logic [7:0] boot, input logic [7:0] ping,
                               input logic [7:0] ack, input logic [7:0] p0,
                               input logic [7:0] p1, input logic [7:0] p2,
                               input logic [15:0] base);
    write_cfg(pbrf_pkg::CFG_BOOT_PING, {8'd0, boot});
    write_cfg(pbrf_pkg::CFG_PING, {8'd0, ping});
    write_cfg(pbrf_pkg::CFG_ACK, {8'd0, ack});
    write_cfg(pbrf_pkg::CFG_POLL0, {8'd0, p0});
    write_cfg(pbrf_pkg::CFG_POLL1, {8'd0, p1});
    write_cfg(pbrf_pkg::CFG_POLL2, {8'd0, p2});
    write_cfg(pbrf_pkg::CFG_READ_BASE, base);
  endtask

  task automatic enqueue(input pbrf_pkg::in_item_t it, input bit drain);
    stim_t s;
    s.item = it;
    s.drain_first = drain;
    send_queue.push_back(s);
  endtask

  task automatic send(input logic [1:0] cmd, input logic [7:0] b,
                      input logic [15:0] addr, input logic [15:0] cnt);
    pbrf_pkg::in_item_t it;
    it.command = cmd;
    it.data_byte = b;
    it.read_address = addr;
    it.read_count = cnt;
    enqueue(it, 1'b0);
  endtask

  task automatic settle();
    while (send_queue.size() > 0 || in_valid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    int made;
    int pick;
    int avail;
    int offs;
    int most;
    pbrf_pkg::in_item_t it;
    made = 0;
    while (made < n) begin
      it.command = pbrf_pkg::CMD_BYTE;
      it.data_byte = 8'($urandom);
      it.read_address = 16'($urandom);
      it.read_count = 16'($urandom);
      avail = 65536 - int'(base_addr);
      if (avail > FILE_WORDS) avail = FILE_WORDS;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        if ($urandom_range(0, 4) != 0)
          it.data_byte = 8'($urandom_range(0, FILE_WORDS - pbrf_pkg::FILE_REG_OFFSET - 1));
        enqueue(it, 1'b0);
        it.data_byte = 8'($urandom);
        enqueue(it, 1'b0);
        it.data_byte = 8'($urandom);
        enqueue(it, 1'b0);
        made += 3;
      end else if (pick < 48) begin
        it.data_byte = $urandom_range(0, 1) ? boot_code : ping_cmd;
        enqueue(it, 1'b0);
        made++;
      end else if (pick < 63) begin
        it.command = pbrf_pkg::CMD_REQUEST;
        enqueue(it, 1'b0);
        made++;
      end else if (pick < 88) begin
        it.command = pbrf_pkg::CMD_READ;
        if ($urandom_range(0, 9) == 0) begin
          offs = 0;
          it.read_count = 16'(avail);
        end else begin
          offs = $urandom_range(0, avail - 1);
          most = avail - offs;
          if (most > 4 && $urandom_range(0, 5) != 0) most = 4;
          it.read_count = 16'($urandom_range(0, most));
        end
        it.read_address = 16'(int'(base_addr) + offs);
        enqueue(it, 1'b0);
        made++;
      end else if (pick < 96) begin
        it.command = pbrf_pkg::CMD_READ;
        case ($urandom_range(0, 2))
          0: it.read_address = base_addr - 16'd1;
          1: begin
            offs = $urandom_range(0, avail - 1);
            it.read_address = 16'(int'(base_addr) + offs);
            it.read_count = 16'(avail - offs + $urandom_range(1, 3));
          end
          default: ;
        endcase
        enqueue(it, 1'b0);
        made++;
      end else if (pick < 98) begin
        it.command = 2'd3;
        enqueue(it, 1'b0);
      end else begin
        enqueue(it, 1'b0);
        made++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_item(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (send_queue.size() > 0 &&
                     !(send_queue[0].drain_first && awaited_results.size() > 0)) begin
          next_stim = send_queue.pop_front();
          in_data <= next_stim.item;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (squeeze_req && !squeeze_done) begin
      squeeze_done = 1'b1;
      squeeze_left = SQUEEZE_CYCLES;
      out_stall <= 1'b1;
    end else if (squeeze_left > 0) begin
      squeeze_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 80);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ~out_stall;
        2: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_data));
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", 16'(out_data.kind), 16'(want.kind));
        check_field("reply_byte", 16'(out_data.reply_byte), 16'(want.reply_byte));
        check_field("reg_word", out_data.reg_word, want.reg_word);
        check_field("read_status", 16'(out_data.read_status), 16'(want.read_status));
        check_field("last", 16'(out_data.last), 16'(want.last));
      end
    end
  end

  initial begin
    boot_code = pbrf_pkg::BOOT_PING_RST;
    ping_cmd = pbrf_pkg::PING_RST;
    ack_val = pbrf_pkg::ACK_RST;
    poll_regs[0] = pbrf_pkg::POLL0_RST;
    poll_regs[1] = pbrf_pkg::POLL1_RST;
    poll_regs[2] = pbrf_pkg::POLL2_RST;
    base_addr = pbrf_pkg::READ_BASE_RST;
    mphase = pbrf_pkg::PH_IDLE;
    polls_done = 0;
    cur_reg = '0;
    held_low = '0;
    reply_reg = '0;
    for (int i = 0; i < FILE_WORDS; i++) words[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed items under the reset configuration.
    send(pbrf_pkg::CMD_REQUEST, 8'd0, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_READ, 8'd0, 16'd1000, 16'd20);
    send(pbrf_pkg::CMD_BYTE, 8'd1, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_REQUEST, 8'd0, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'd2, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_REQUEST, 8'd0, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'd0, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'hff, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'hff, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'd2, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'd5, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'd2, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'd2, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'h34, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'h12, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'd2, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_REQUEST, 8'd0, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'd17, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'h00, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'h80, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'd18, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'h5a, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_BYTE, 8'ha5, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_READ, 8'd0, 16'd1000, 16'd20);
    send(pbrf_pkg::CMD_READ, 8'd0, 16'd999, 16'd1);
    send(pbrf_pkg::CMD_READ, 8'd0, 16'd1001, 16'd20);
    send(pbrf_pkg::CMD_READ, 8'd0, 16'd1019, 16'd1);
    send(pbrf_pkg::CMD_READ, 8'd0, 16'd1000, 16'd0);
    send(pbrf_pkg::CMD_READ, 8'd0, 16'd1020, 16'd0);
    send(2'd3, 8'hff, 16'hffff, 16'hffff);
    send(pbrf_pkg::CMD_READ, 8'hff, 16'hffff, 16'hffff);
    send(pbrf_pkg::CMD_READ, 8'd0, 16'd1000, 16'd20);
    settle();

    write_all_cfg(8'd0, 8'hff, 8'hff, 8'hff, 8'd0, 8'd128, 16'd0);
    queue_random(20);
    settle();

    write_all_cfg(8'd7, 8'd7, 8'd0, 8'd3, 8'd4, 8'd5, 16'hffff);
    send(pbrf_pkg::CMD_BYTE, 8'd7, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_REQUEST, 8'd0, 16'd0, 16'd0);
    send(pbrf_pkg::CMD_READ, 8'd0, 16'hffff, 16'd1);
    queue_random(20);
    settle();

    write_all_cfg(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 16'($urandom_range(0, 60000)));
    queue_random(15);
    squeeze_req <= 1'b1;
    send(pbrf_pkg::CMD_READ, 8'd0, base_addr, 16'd20);
    drain_item = '0;
    drain_item.command = pbrf_pkg::CMD_REQUEST;
    enqueue(drain_item, 1'b1);
    queue_random(15);
    settle();

    write_cfg(pbrf_pkg::CFG_READ_BASE, 16'd65520);
    write_cfg(pbrf_pkg::CFG_ACK, 16'd170);
    queue_random(20);
    settle();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
